FILE: rtl/ultrasonic_echo_ranger_core_macros.svh
// Assertion macros shared by the ranger RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ULTRASONIC_ECHO_RANGER_CORE_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_CORE_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define UER_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("uer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define UER_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("uer assertion failed");

`else

`define UER_ASSERT_IMP(label, ante, cons)
`define UER_ASSERT_NXT(label, ante, cons)

`endif

`endif

FILE: rtl/uer_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

	// Field widths.
	localparam int PERIOD_W = 16;
	localparam int TRIG_W   = 8;
	localparam int SCALE_W  = 8;
	localparam int PULSE_W  = 22;
	localparam int DIST_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Default wrap limit before a capture is ended as a timeout.
	localparam int unsigned MAX_WRAPS_DEF = 63;

	// Register reset values.
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'hFFFF;
	localparam logic [TRIG_W-1:0]   TRIG_RST   = 8'd30;
	localparam logic [SCALE_W-1:0]  SCALE_RST  = 8'd17;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_TIMER_PERIOD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_SCALE = 2'd2;

	// Saturation limits.
	localparam logic [PULSE_W-1:0] PULSE_MAX = 22'h3FFFFF;
	localparam logic [DIST_W-1:0]  DIST_MAX  = 8'hFF;

	// Width times scale is 30 bits wide.
	localparam int PROD_W = PULSE_W + SCALE_W;

	// Division by 1000 through a reciprocal. Below the saturation limit the
	// scaled product fits in 18 bits, where the reciprocal is exact.
	localparam int unsigned DistDiv = 1000;
	localparam int unsigned DIST_SAT = 256 * DistDiv;
	localparam int DIV_IN_W    = 18;
	localparam int RECIP_SHIFT = 28;
	localparam int RECIP_W     = 19;
	localparam logic [RECIP_W-1:0] RECIP_MUL =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + DistDiv - 1) / DistDiv);
	localparam int RECIP_PROD_W = DIV_IN_W + RECIP_W;

	// Configuration values as seen by the datapath.
	typedef struct packed {
		logic [PERIOD_W-1:0] timer_period;
		logic [TRIG_W-1:0]   trigger_ticks;
		logic [SCALE_W-1:0]  distance_scale;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic step;
		logic mul;
		logic add;
		logic prod;
		logic div;
		logic load;
	} dp_cmd_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_PROD,
		ST_DIV,
		ST_LOAD
	} ctrl_state_t;

endpackage

`default_nettype wire

FILE: rtl/uer_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module uer_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [uer_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [uer_pkg::CFG_DATA_W-1:0]    cfg_data,
	output uer_pkg::cfg_t                     cfg
);
	import uer_pkg::*;

	logic [PERIOD_W-1:0] timer_period_q;
	logic [TRIG_W-1:0]   trigger_ticks_q;
	logic [SCALE_W-1:0]  distance_scale_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;

	// Register file; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_period_q   <= PERIOD_RST;
			trigger_ticks_q  <= TRIG_RST;
			distance_scale_q <= SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TIMER_PERIOD:   timer_period_q   <= cfg_data[PERIOD_W-1:0];
				CFG_TRIGGER_TICKS:  trigger_ticks_q  <= cfg_data[TRIG_W-1:0];
				CFG_DISTANCE_SCALE: distance_scale_q <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.timer_period   = timer_period_q;
	assign cfg.trigger_ticks  = trigger_ticks_q;
	assign cfg.distance_scale = distance_scale_q;

endmodule

`default_nettype wire

FILE: rtl/uer_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "ultrasonic_echo_ranger_core_macros.svh"

module uer_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output uer_pkg::dp_cmd_t cmd
);
	import uer_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;
	logic        load_ok;

	// The output register can take a result when empty or being drained.
	assign load_ok = !out_valid_q || m_tready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_MUL;
			ST_MUL:  state_d = ST_ADD;
			ST_ADD:  state_d = ST_PROD;
			ST_PROD: state_d = ST_DIV;
			ST_DIV:  state_d = ST_LOAD;
			ST_LOAD: if (load_ok) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs and datapath commands.
	always_comb begin
		s_tready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.step = s_tvalid;
			end
			ST_MUL:  cmd.mul  = 1'b1;
			ST_ADD:  cmd.add  = 1'b1;
			ST_PROD: cmd.prod = 1'b1;
			ST_DIV:  cmd.div  = 1'b1;
			ST_LOAD: cmd.load = load_ok;
			default: ;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output valid flag: set on a load, cleared when a result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

	`UER_ASSERT_NXT(a_step_starts_math, cmd.step, state_q == ST_MUL)
	`UER_ASSERT_NXT(a_load_fills_output, cmd.load, m_tvalid && state_q == ST_IDLE)
	`UER_ASSERT_IMP(a_valid_rises_after_load, $rose(m_tvalid), $past(state_q) == ST_LOAD)

endmodule

`default_nettype wire

FILE: rtl/uer_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "ultrasonic_echo_ranger_core_macros.svh"

module uer_datapath #(
	parameter int unsigned MAX_WRAPS = uer_pkg::MAX_WRAPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  uer_pkg::dp_cmd_t            cmd,
	input  uer_pkg::cfg_t               cfg,
	input  logic                        echo_level,
	input  logic                        start_request,
	output logic                        trigger_drive,
	output logic                        busy_state,
	output logic                        result_valid,
	output logic [uer_pkg::PULSE_W-1:0] pulse_ticks,
	output logic [uer_pkg::DIST_W-1:0]  distance_out,
	output logic                        timed_out
);
	import uer_pkg::*;

	localparam int WC_W  = $clog2(MAX_WRAPS + 1);
	localparam logic [WC_W-1:0] WC_MAX = WC_W'(MAX_WRAPS);
	localparam int RAW_W = WC_W + PERIOD_W + 1;
	localparam int SUM_W = (RAW_W + 1 > PULSE_W + 1) ? RAW_W + 1 : PULSE_W + 1;

	// Measurement state.
	logic                echo_prev_q;
	logic                capturing_q;
	logic                capture_done_q;
	logic [WC_W-1:0]     wrap_count_q;
	logic [PERIOD_W-1:0] tick_counter_q;
	logic [PERIOD_W-1:0] latched_count_q;
	logic                busy_q;
	logic [TRIG_W-1:0]   trigger_left_q;

	// Next values of the measurement state for one tick.
	logic                cap_n;
	logic                cd_n;
	logic [WC_W-1:0]     wc_n;
	logic [PERIOD_W-1:0] tc_n;
	logic [PERIOD_W-1:0] lc_n;
	logic                busy_n;
	logic [TRIG_W-1:0]   tl_n;
	logic                report;
	logic                tout_n;
	logic [WC_W-1:0]     rep_wc_d;

	// Snapshot of one tick for the arithmetic steps.
	logic                rep_valid_q;
	logic                rep_tout_q;
	logic                rep_trig_q;
	logic                rep_busy_q;
	logic [WC_W-1:0]     rep_wc_q;
	logic [PERIOD_W-1:0] rep_lc_q;
	logic [PERIOD_W-1:0] rep_period_q;
	logic [SCALE_W-1:0]  rep_scale_q;

	// Arithmetic registers.
	logic [RAW_W-1:0]        raw_q;
	logic [SUM_W-1:0]        sum;
	logic [PULSE_W-1:0]      width_q;
	logic [PROD_W-1:0]       prod_q;
	logic [RECIP_PROD_W-1:0] recip_prod;
	logic [DIST_W-1:0]       dist_q;

	// Output register.
	logic                out_trig_q;
	logic                out_busy_q;
	logic                out_valid_q;
	logic [PULSE_W-1:0]  out_pulse_q;
	logic [DIST_W-1:0]   out_dist_q;
	logic                out_tout_q;

	// One tick: trigger countdown, capture, then report or start.
	always_comb begin
		logic rising;
		logic falling;

		rising  = echo_level && !echo_prev_q;
		falling = !echo_level && echo_prev_q;

		tl_n   = (trigger_left_q != '0) ? trigger_left_q - TRIG_W'(1) : trigger_left_q;
		cap_n  = capturing_q;
		cd_n   = capture_done_q;
		wc_n   = wrap_count_q;
		tc_n   = tick_counter_q;
		lc_n   = latched_count_q;
		busy_n = busy_q;

		if (!capture_done_q) begin
			if (capturing_q) begin
				if (tick_counter_q >= cfg.timer_period) begin
					tc_n = '0;
					if (wrap_count_q >= WC_MAX) begin
						cd_n = 1'b1;
						lc_n = cfg.timer_period;
					end else begin
						wc_n = wrap_count_q + WC_W'(1);
					end
				end else begin
					tc_n = tick_counter_q + PERIOD_W'(1);
				end
				if (!cd_n && falling) begin
					cd_n = 1'b1;
					lc_n = tc_n;
				end
			end else if (rising) begin
				cap_n = 1'b1;
				wc_n  = '0;
				tc_n  = '0;
				lc_n  = '0;
			end
		end

		report   = busy_q && cd_n;
		tout_n   = (wc_n >= WC_MAX) && (lc_n == cfg.timer_period);
		rep_wc_d = wc_n;

		if (report) begin
			cap_n  = 1'b0;
			cd_n   = 1'b0;
			wc_n   = '0;
			busy_n = 1'b0;
		end else if (!busy_q && start_request) begin
			tl_n   = cfg.trigger_ticks;
			busy_n = 1'b1;
		end
	end

	// Measurement state update, once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_prev_q     <= 1'b0;
			capturing_q     <= 1'b0;
			capture_done_q  <= 1'b0;
			wrap_count_q    <= '0;
			tick_counter_q  <= '0;
			latched_count_q <= '0;
			busy_q          <= 1'b0;
			trigger_left_q  <= '0;
		end else if (cmd.step) begin
			echo_prev_q     <= echo_level;
			capturing_q     <= cap_n;
			capture_done_q  <= cd_n;
			wrap_count_q    <= wc_n;
			tick_counter_q  <= tc_n;
			latched_count_q <= lc_n;
			busy_q          <= busy_n;
			trigger_left_q  <= tl_n;
		end
	end

	// Snapshot of the tick's report inputs.
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			rep_valid_q  <= report;
			rep_tout_q   <= report && tout_n;
			rep_trig_q   <= (tl_n != '0);
			rep_busy_q   <= busy_n;
			rep_wc_q     <= rep_wc_d;
			rep_lc_q     <= lc_n;
			rep_period_q <= cfg.timer_period;
			rep_scale_q  <= cfg.distance_scale;
		end
	end

	// Wraps times the full period length.
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			raw_q <= RAW_W'(rep_wc_q) * RAW_W'({1'b0, rep_period_q} + (PERIOD_W + 1)'(1));
		end
	end

	// Add the latched count and saturate to the pulse width range.
	assign sum = SUM_W'(raw_q) + SUM_W'(rep_lc_q);

	always_ff @(posedge clk) begin
		if (cmd.add) begin
			width_q <= (sum > SUM_W'(PULSE_MAX)) ? PULSE_MAX : sum[PULSE_W-1:0];
		end
	end

	// Width times distance scale.
	always_ff @(posedge clk) begin
		if (cmd.prod) begin
			prod_q <= PROD_W'(width_q) * PROD_W'(rep_scale_q);
		end
	end

	// Divide by 1000 through the reciprocal, saturating at the top code.
	assign recip_prod = RECIP_PROD_W'(prod_q[DIV_IN_W-1:0]) * RECIP_PROD_W'(RECIP_MUL);

	always_ff @(posedge clk) begin
		if (cmd.div) begin
			if (prod_q >= PROD_W'(DIST_SAT)) begin
				dist_q <= DIST_MAX;
			end else begin
				dist_q <= recip_prod[RECIP_SHIFT+DIST_W-1:RECIP_SHIFT];
			end
		end
	end

	// Output register; result fields are zero when no measurement is reported.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_trig_q  <= rep_trig_q;
			out_busy_q  <= rep_busy_q;
			out_valid_q <= rep_valid_q;
			out_pulse_q <= rep_valid_q ? width_q : '0;
			out_dist_q  <= rep_valid_q ? dist_q : '0;
			out_tout_q  <= rep_tout_q;
		end
	end

	assign trigger_drive = out_trig_q;
	assign busy_state    = out_busy_q;
	assign result_valid  = out_valid_q;
	assign pulse_ticks   = out_pulse_q;
	assign distance_out  = out_dist_q;
	assign timed_out     = out_tout_q;

	`UER_ASSERT_IMP(a_done_needs_capture, capture_done_q, capturing_q)
	`UER_ASSERT_IMP(a_wraps_in_range, 1'b1, wrap_count_q <= WC_MAX)
	`UER_ASSERT_NXT(a_report_goes_idle, cmd.step && report, !busy_q && !capture_done_q)

endmodule

`default_nettype wire

FILE: rtl/ultrasonic_echo_ranger_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Ultrasonic echo ranger: each transaction on the slave stream is one 1 us
// timebase tick carrying the sampled echo level and a start request, and each
// tick yields exactly one transaction on the master stream with the trigger
// drive, the busy flag and, in the tick that ends a measurement, the echo
// width in ticks (wraps times period plus one, plus the latched count,
// saturated to 22 bits), the distance (width times scale over 1000, saturated
// at 255) and a timeout flag; m_tuser marks that a measurement is reported.
// Per tick, the accept cycle updates the capture state, then four arithmetic
// steps run on registered operands (wraps times period, add and saturate,
// scale product, reciprocal divide by 1000), and a last step loads the output
// register, which holds off while the previous result is not yet taken.
// Register writes take effect on the next tick.
module ultrasonic_echo_ranger_core #(
	parameter int unsigned MAX_WRAPS = uer_pkg::MAX_WRAPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Tick input stream. s_tdata: [0] echo_level, [1] start_request.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,
	// Result stream. m_tdata: [0] trigger_drive, [1] busy_state,
	// [23:2] pulse_ticks, [31:24] distance_out, [32] timed_out.
	// m_tuser: [0] result_valid.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [39:0]                    m_tdata,
	output logic                           m_tuser,
	// Register write channel.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data
);
	import uer_pkg::*;

	cfg_t               cfg;
	dp_cmd_t            cmd;
	logic               trigger_drive;
	logic               busy_state;
	logic               result_valid;
	logic [PULSE_W-1:0] pulse_ticks;
	logic [DIST_W-1:0]  distance_out;
	logic               timed_out;

	uer_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	uer_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	uer_datapath #(
		.MAX_WRAPS (MAX_WRAPS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg           (cfg),
		.echo_level    (s_tdata[0]),
		.start_request (s_tdata[1]),
		.trigger_drive (trigger_drive),
		.busy_state    (busy_state),
		.result_valid  (result_valid),
		.pulse_ticks   (pulse_ticks),
		.distance_out  (distance_out),
		.timed_out     (timed_out)
	);

	// Pack the result fields, lowest bit first, zero filled to whole bytes.
	assign m_tdata = {7'd0, timed_out, distance_out, pulse_ticks, busy_state, trigger_drive};
	assign m_tuser = result_valid;

endmodule

`default_nettype wire

FILE: sim/ultrasonic_echo_ranger_core_test.sv
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_core_test;
	import uer_pkg::*;

	localparam int unsigned WRAP_LIMIT    = MAX_WRAPS_DEF;
	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned MAX_IDLE      = 14;
	localparam int unsigned PHASE_TICKS   = 32;

	// One tick's worth of output fields.
	typedef struct packed {
		bit               trigger_drive;
		bit               busy_state;
		bit               result_valid;
		bit [PULSE_W-1:0] pulse_ticks;
		bit [DIST_W-1:0]  distance_out;
		bit               timed_out;
	} tick_report_t;

	// Our own copy of the ranging state.
	typedef struct packed {
		bit        echo_prev;
		bit        capturing;
		bit        capture_done;
		bit [5:0]  wrap_count;
		bit [15:0] tick_counter;
		bit [15:0] latched_count;
		bit        busy;
		bit [7:0]  trigger_left;
	} ranger_state_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [39:0]           m_tdata;
	logic                  m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	cfg_t          ranger_cfg;
	ranger_state_t ranger;
	tick_report_t  tick_reports_due[$];
	int unsigned   fault_count = 0;
	int unsigned   ticks_sent  = 0;
	bit            tx_steady   = 1'b0;
	bit            rx_steady   = 1'b0;

	ultrasonic_echo_ranger_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial forever #5 clk = ~clk;

	// Advance the ranging state by one tick and return the fields it reports.
	function automatic tick_report_t ranger_tick_outcome(bit echo, bit start);
		tick_report_t    rep;
		bit              rising;
		bit              falling;
		longint unsigned width;
		longint unsigned dist_val;
		rep = '0;
		rising = echo && !ranger.echo_prev;
		falling = !echo && ranger.echo_prev;

		// The trigger countdown steps first.
		if (ranger.trigger_left != 0)
			ranger.trigger_left--;

		// Capture: counter step with wrap or timeout, then the falling latch,
		// then arming on a rising edge.
		if (!ranger.capture_done) begin
			if (ranger.capturing) begin
				if (ranger.tick_counter >= ranger_cfg.timer_period) begin
					ranger.tick_counter = '0;
					if (ranger.wrap_count >= WRAP_LIMIT) begin
						ranger.capture_done = 1'b1;
						ranger.latched_count = ranger_cfg.timer_period;
					end else begin
						ranger.wrap_count++;
					end
				end else begin
					ranger.tick_counter++;
				end
				if (!ranger.capture_done && falling) begin
					ranger.capture_done = 1'b1;
					ranger.latched_count = ranger.tick_counter;
				end
			end else if (rising) begin
				ranger.capturing = 1'b1;
				ranger.wrap_count = '0;
				ranger.tick_counter = '0;
				ranger.latched_count = '0;
			end
		end
		ranger.echo_prev = echo;

		// Report a finished capture while busy, otherwise take a start request.
		if (ranger.busy && ranger.capture_done) begin
			width = ranger.wrap_count * (ranger_cfg.timer_period + 64'd1)
				+ ranger.latched_count;
			if (width > PULSE_MAX)
				width = PULSE_MAX;
			dist_val = width * ranger_cfg.distance_scale / 1000;
			if (dist_val > DIST_MAX)
				dist_val = DIST_MAX;
			rep.result_valid = 1'b1;
			rep.pulse_ticks = width[PULSE_W-1:0];
			rep.distance_out = dist_val[DIST_W-1:0];
			rep.timed_out = (ranger.wrap_count >= WRAP_LIMIT) &&
				(ranger.latched_count == ranger_cfg.timer_period);
			ranger.capturing = 1'b0;
			ranger.capture_done = 1'b0;
			ranger.wrap_count = '0;
			ranger.busy = 1'b0;
		end else if (!ranger.busy && start) begin
			ranger.trigger_left = ranger_cfg.trigger_ticks;
			ranger.busy = 1'b1;
		end

		rep.trigger_drive = (ranger.trigger_left != 0);
		rep.busy_state = ranger.busy;
		return rep;
	endfunction

	function automatic void flag_fault(string what, longint unsigned want,
		longint unsigned got);
		if (fault_count < 10)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		fault_count++;
	endfunction

	// Send one tick as a transaction after a random gap; the valid stays high
	// afterwards so that a following tick with no gap keeps it up.
	task automatic send_tick(bit echo, bit start);
		int unsigned gap;
		gap = tx_steady ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, start, echo};
		do @(posedge clk); while (!s_tready);
		tick_reports_due.push_back(ranger_tick_outcome(echo, start));
		ticks_sent++;
	endtask

	// Stop sending and wait until every expected result has arrived.
	task automatic await_reports();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (tick_reports_due.size() != 0);
	endtask

	// Write all three registers while the block is idle.
	task automatic set_registers(bit [15:0] period, bit [7:0] trig, bit [7:0] scale);
		logic [CFG_IDX_W-1:0]  idx [3];
		logic [CFG_DATA_W-1:0] val [3];
		await_reports();
		idx = '{CFG_TIMER_PERIOD, CFG_TRIGGER_TICKS, CFG_DISTANCE_SCALE};
		val = '{period, CFG_DATA_W'(trig), CFG_DATA_W'(scale)};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		ranger_cfg.timer_period = period;
		ranger_cfg.trigger_ticks = trig;
		ranger_cfg.distance_scale = scale;
	endtask

	// Hold the echo at one level; start requests may be sprinkled in.
	task automatic hold_echo(bit level, int unsigned ticks, bit stray_starts);
		repeat (ticks) send_tick(level, stray_starts && ($urandom_range(0, 3) == 0));
	endtask

	// Drive the echo until the measurement has been reported. When no capture
	// is running, a fresh echo pulse is made so that the block always finishes.
	task automatic finish_measurement(bit stray_starts);
		while (ranger.busy) begin
			if (ranger.capturing || ranger.capture_done)
				send_tick(1'b0, stray_starts && ($urandom_range(0, 3) == 0));
			else
				send_tick(!ranger.echo_prev, stray_starts && ($urandom_range(0, 3) == 0));
		end
	endtask

	// One well-formed measurement with a random echo width for the period.
	task automatic ranging_cycle(bit stray);
		int unsigned span;
		int unsigned period;
		period = ranger_cfg.timer_period;
		span = $urandom_range(1, 24);
		case ($urandom_range(0, 9))
			0: if (period <= 3)
				span = 64 * (period + 1) + $urandom_range(0, 3);
			1: if (period <= 3)
				span = 64 * (period + 1) - 1;
			2, 3: if (period <= 64)
				span = (period + 1) * $urandom_range(1, 3) + $urandom_range(0, 2) - 1;
			default: ;
		endcase
		if (span == 0)
			span = 1;
		send_tick(1'($urandom_range(0, 1)), 1'b1);
		hold_echo(1'b0, $urandom_range(1, 6), stray);
		hold_echo(1'b1, span, stray);
		finish_measurement(stray);
	endtask

	// Idle ticks, then a short echo at the register reset values.
	task automatic test_default_measurement();
		hold_echo(1'b0, 3, 1'b0);
		send_tick(1'b0, 1'b1);
		hold_echo(1'b0, 2, 1'b0);
		hold_echo(1'b1, 5, 1'b1);
		finish_measurement(1'b1);
	endtask

	// Wrap-limit timeout with a zero period and no trigger pulse, then an echo
	// that falls exactly on the full count.
	task automatic test_timeout_cases();
		set_registers(16'd0, 8'd0, 8'd255);
		send_tick(1'b0, 1'b1);
		hold_echo(1'b1, 70, 1'b0);
		finish_measurement(1'b0);
		set_registers(16'd1, 8'd1, 8'd255);
		send_tick(1'b0, 1'b1);
		hold_echo(1'b0, 1, 1'b0);
		hold_echo(1'b1, 64 * 2 - 1, 1'b0);
		finish_measurement(1'b0);
	endtask

	// A capture finished while idle waits for the next start; a start in the
	// reporting tick and starts while busy are ignored.
	task automatic test_idle_capture();
		set_registers(16'd5, 8'd3, 8'd0);
		hold_echo(1'b0, 1, 1'b0);
		hold_echo(1'b1, 4, 1'b0);
		hold_echo(1'b0, 3, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b1);
		hold_echo(1'b0, 2, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b1);
		hold_echo(1'b1, 2, 1'b0);
		finish_measurement(1'b0);
	endtask

	// Random measurements and noise over several register settings.
	task automatic test_random_ranging();
		bit [15:0]   periods [8];
		bit [7:0]    trigs [8];
		bit [7:0]    scales [8];
		int unsigned phase_start;
		periods = '{16'd1, 16'd0, 16'd3, 16'd7, 16'd2, 16'd15, 16'd65535, 16'd40};
		trigs   = '{8'd1, 8'd255, 8'd8, 8'd0, 8'd5, 8'd3, 8'd200, 8'd30};
		scales  = '{8'd0, 8'd255, 8'd128, 8'd9, 8'd255, 8'd100, 8'd255, 8'd17};
		for (int p = 0; p < 8; p++) begin
			set_registers(periods[p], trigs[p], scales[p]);
			phase_start = ticks_sent;
			while (ticks_sent - phase_start < PHASE_TICKS) begin
				tx_steady = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 5) == 0) begin
					repeat ($urandom_range(8, 24))
						send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
				ranging_cycle(1'($urandom_range(0, 1)));
				// Now and then hold the stream until the block has drained.
				if ($urandom_range(0, 7) == 0)
					await_reports();
			end
		end
		tx_steady = 1'b0;
	endtask

	// Take each result transaction after a random stall and check it against
	// the oldest expectation.
	initial begin : result_checker
		tick_report_t want;
		tick_report_t got;
		int unsigned  stall;
		int unsigned  taken;
		taken = 0;
		forever begin
			if (taken % 32 == 0)
				rx_steady = ($urandom_range(0, 3) == 0);
			stall = rx_steady ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken++;
			got.trigger_drive = m_tdata[0];
			got.busy_state    = m_tdata[1];
			got.pulse_ticks   = m_tdata[23:2];
			got.distance_out  = m_tdata[31:24];
			got.timed_out     = m_tdata[32];
			got.result_valid  = m_tuser;
			if (tick_reports_due.size() == 0) begin
				if (fault_count < 10)
					$display("%0t: result arrived with nothing expected", $time);
				fault_count++;
			end else begin
				want = tick_reports_due.pop_front();
				if (got.trigger_drive != want.trigger_drive)
					flag_fault("trigger_drive", want.trigger_drive, got.trigger_drive);
				if (got.busy_state != want.busy_state)
					flag_fault("busy_state", want.busy_state, got.busy_state);
				if (got.result_valid != want.result_valid)
					flag_fault("result_valid", want.result_valid, got.result_valid);
				if (got.pulse_ticks != want.pulse_ticks)
					flag_fault("pulse_ticks", want.pulse_ticks, got.pulse_ticks);
				if (got.distance_out != want.distance_out)
					flag_fault("distance_out", want.distance_out, got.distance_out);
				if (got.timed_out != want.timed_out)
					flag_fault("timed_out", want.timed_out, got.timed_out);
			end
		end
	end

	// End the run if it hangs.
	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin : main_sequence
		ranger = '0;
		ranger_cfg.timer_period = PERIOD_RST;
		ranger_cfg.trigger_ticks = TRIG_RST;
		ranger_cfg.distance_scale = SCALE_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_measurement();
		test_timeout_cases();
		test_idle_capture();
		test_random_ranging();
		await_reports();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/uer_pkg.sv
rtl/uer_cfg_regs.sv
rtl/uer_ctrl.sv
rtl/uer_datapath.sv
rtl/ultrasonic_echo_ranger_core.sv
sim/ultrasonic_echo_ranger_core_test.sv
